[hdl/strip_hit_clusterer_defines.svh]
// Assertion macros shared by the strip hit clusterer RTL.
`ifndef STRIP_HIT_CLUSTERER_DEFINES_SVH
`define STRIP_HIT_CLUSTERER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/shc_pkg.sv]
// Types and constants of the strip hit clusterer.
package shc_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_MASK  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Register file.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_ADDR = 2'd0;
  localparam logic [7:0] THRESHOLD_RESET = 8'd250;

  // Default geometry.
  localparam int NUM_STRIPS_DEF  = 256;
  localparam int NUM_SENSORS_DEF = 4;

  // One input request.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] sensor;
    logic [7:0] strip;
    logic [7:0] amplitude;
    logic       mask_value;
  } hit_item_t;

  // One emitted cluster.
  typedef struct packed {
    logic [1:0] cluster_sensor;
    logic [7:0] start_strip;
    logic [7:0] extra_strips;
  } cluster_t;

endpackage

[hdl/strip_hit_clusterer.sv]
// Strip hit clusterer: mask filter, adjacency clustering and output register.
//
// Usage: hits, mask writes and end-of-sensor flushes enter on the in_ channel
// (valid/ready) as hit_item_t requests, hits in ascending strip order. Each
// hit above the amplitude threshold and not masked bad either widens the open
// cluster or opens a new one, closing any open cluster first; closed clusters
// leave on the out_ channel as cluster_t requests. A flush emits the open cluster if there is one.
// The threshold sits at byte address 0 of the cfg_ APB port.
// Flow: the edge that accepts a request also does the registered mask
// read; the edge at which the processing stage moves on runs the cluster
// logic and loads the output register.
// Throughput: one request per cycle while in_ready is high; the single port
// of the mask memory is used at most once per request, at the edge that accepts it.
// Reset: rst_n clears the control state and the threshold returns to 250.
// The mask memory is then cleared by a pass over all NUM_SENSORS*NUM_STRIPS
// entries (1024 with the defaults), one entry per cycle; in_ready stays low during
// that pass, while configuration writes are taken as usual.
// Stall: while out_ready is low a result waits in the output register, one
// more request waits in the processing stage, and in_ready drops.
`include "strip_hit_clusterer_defines.svh"

module strip_hit_clusterer #(
  parameter int NUM_STRIPS  = shc_pkg::NUM_STRIPS_DEF,
  parameter int NUM_SENSORS = shc_pkg::NUM_SENSORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  shc_pkg::hit_item_t                  in_data,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output shc_pkg::cluster_t                   out_data,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [shc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [shc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [shc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import shc_pkg::*;

  localparam int DEPTH  = NUM_SENSORS * NUM_STRIPS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_t;

  // Configuration register.
  logic [7:0] threshold_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == REG_THRESHOLD_ADDR);
  assign cfg_prdata = (cfg_paddr == REG_THRESHOLD_ADDR) ?
                      {{(CFG_DATA_W-8){1'b0}}, threshold_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      threshold_r <= cfg_pwdata[7:0];
    end
  end

  // Clearing pass over the mask memory after reset.
  clr_state_t        state_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          state_r <= ST_RUN;
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  // Handshake of the processing stage and the output register.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_fire;
  logic in_fire;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_RUN) && (!s1_valid_r || s1_fire);
  assign in_fire  = in_valid && in_ready;

  // Range checks and mask address of the incoming request.
  logic              in_sensor_ok;
  logic              in_strip_ok;
  logic [ADDR_W-1:0] in_addr;

  assign in_sensor_ok = ({30'd0, in_data.sensor} < 32'(NUM_SENSORS));
  assign in_strip_ok  = ({24'd0, in_data.strip} < 32'(NUM_STRIPS));
  assign in_addr      = ADDR_W'(32'(in_data.sensor) * 32'(NUM_STRIPS) +
                                32'(in_data.strip));

  // Mask memory: one port, cleared by the pass, else read or written by a request.
  logic              mask_mem [DEPTH];
  logic              mask_rd_r;
  logic              mem_we;
  logic              mem_re;
  logic              mem_wdata;
  logic [ADDR_W-1:0] mem_addr;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_re    = 1'b0;
      mem_wdata = 1'b0;
      mem_addr  = clr_addr_r;
    end else begin
      mem_we    = in_fire && in_sensor_ok && in_strip_ok && (in_data.kind == KIND_MASK);
      mem_re    = in_fire && in_sensor_ok && in_strip_ok && (in_data.kind == KIND_HIT);
      mem_wdata = in_data.mask_value;
      mem_addr  = in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mask_rd_r <= mask_mem[mem_addr];
    end
  end

  // Processing stage registers.
  hit_item_t s1_item_r;
  logic      s1_sensor_ok_r;
  logic      s1_strip_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r      <= in_data;
      s1_sensor_ok_r <= in_sensor_ok;
      s1_strip_ok_r  <= in_strip_ok;
    end
  end

  // Open cluster state.
  logic       open_r;
  logic [7:0] open_start_r;
  logic [7:0] open_extra_r;
  logic [1:0] open_sensor_r;
  logic       open_nxt;
  logic [7:0] open_start_nxt;
  logic [7:0] open_extra_nxt;
  logic [1:0] open_sensor_nxt;

  // Cluster decision for the request in the processing stage.
  logic       is_flush;
  logic       hit_take;
  logic       adjacent;
  logic       emit;
  logic [9:0] next_strip;

  assign is_flush   = s1_sensor_ok_r && (s1_item_r.kind == KIND_FLUSH);
  assign hit_take   = s1_sensor_ok_r && s1_strip_ok_r && (s1_item_r.kind == KIND_HIT) &&
                      (s1_item_r.amplitude > threshold_r) && !mask_rd_r;
  assign next_strip = {2'b00, open_start_r} + {2'b00, open_extra_r} + 10'd1;
  assign adjacent   = open_r && (s1_item_r.sensor == open_sensor_r) &&
                      ({2'b00, s1_item_r.strip} == next_strip);
  assign emit       = open_r && (is_flush || (hit_take && !adjacent));

  always_comb begin
    open_nxt        = open_r;
    open_start_nxt  = open_start_r;
    open_extra_nxt  = open_extra_r;
    open_sensor_nxt = open_sensor_r;
    if (is_flush) begin
      open_nxt = 1'b0;
    end else if (hit_take && adjacent) begin
      if (open_extra_r != 8'hFF) begin
        open_extra_nxt = open_extra_r + 8'd1;
      end
    end else if (hit_take) begin
      open_nxt        = 1'b1;
      open_start_nxt  = s1_item_r.strip;
      open_extra_nxt  = 8'd0;
      open_sensor_nxt = s1_item_r.sensor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r        <= 1'b0;
      open_start_r  <= 8'd0;
      open_extra_r  <= 8'd0;
      open_sensor_r <= 2'd0;
    end else if (s1_fire) begin
      open_r        <= open_nxt;
      open_start_r  <= open_start_nxt;
      open_extra_r  <= open_extra_nxt;
      open_sensor_r <= open_sensor_nxt;
    end
  end

  // Output register.
  cluster_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_data_r.cluster_sensor <= open_sensor_r;
      out_data_r.start_strip    <= open_start_r;
      out_data_r.extra_strips   <= open_extra_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the clearing pass and the cluster bookkeeping.
  `SHC_ASSERT_NEXT(a_clear_once, clk, rst_n, state_r == ST_RUN, state_r == ST_RUN, "mask clearing restarted")
  `SHC_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, in_valid && in_ready, state_r == ST_RUN, "request accepted during mask clearing")
  `SHC_ASSERT_NEXT(a_hit_opens, clk, rst_n, s1_fire && hit_take, open_r, "accepted hit left no open cluster")
  `SHC_ASSERT_NEXT(a_flush_closes, clk, rst_n, s1_fire && is_flush, !open_r && (out_valid == $past(open_r)), "flush did not close the cluster")

endmodule
